[sv/gld_pkg.sv]
// Shared types, constants and helpers of the GIF LZW decoder.
// Used by every module of the block except gld_ram; depends on nothing else.
`default_nettype none

package gld_pkg;

    localparam int CODE_W  = 12;
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 4;
    localparam int PADDR_W = 3;

    localparam logic [CFG_W-1:0] ICS_RESET = 4'd8;
    localparam logic [CFG_W-1:0] CB_RESET  = 4'd8;

    // Register indexes as decoded from paddr[2].
    localparam logic REG_ICS = 1'b0;
    localparam logic REG_CB  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } in_t;

    typedef struct packed {
        logic [63:0] pixels_0;
        logic [63:0] pixels_1;
        logic [63:0] pixels_2;
        logic [63:0] pixels_3;
        logic [63:0] pixels_4;
        logic [63:0] pixels_5;
        logic [63:0] pixels_6;
        logic [63:0] pixels_7;
        logic [6:0]  pixel_count;
        logic        last;
        logic        end_of_image;
        logic        error;
    } out_t;

    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_LIT,
        CMD_EOI,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              start;
        logic              unknown;
        logic              add;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] addr;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_RUNNING,
        ST_ENDED,
        ST_ERROR
    } status_t;

    typedef enum logic {
        FR_IDLE,
        FR_BUSY
    } fr_state_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_WALK,
        BK_POP
    } bk_state_t;

    function automatic logic [CFG_W-1:0] eff_ics(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v < 4'd2) r = 4'd2;
        if (v > 4'd8) r = 4'd8;
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] eff_cb(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v < 4'd1) r = 4'd1;
        if (v > 4'd8) r = 4'd8;
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/gld_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used for the dictionary and the string stack.
`default_nettype none

module gld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/gld_fifo.sv]
// Short command queue between the code unpacker and the string engine.
// Depends on gld_pkg for the command type.
`default_nettype none

module gld_fifo
    import gld_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_data,
    output      logic full,
    input  wire logic pop,
    output      logic empty,
    output      cmd_t head
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == FULL_CNT);
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wp_next = (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
        end
        if (pop) begin
            rp_next = (rp_reg == LAST_IDX) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[sv/gld_front.sv]
// Front end: takes raster bytes, unpacks LSB-first codes and classifies them.
// Tracks code width and table growth itself; depends on gld_pkg.
`default_nettype none

module gld_front
    import gld_pkg::*;
#(
    parameter int TABLE_DEPTH   = 4096,
    parameter int MAX_CODE_BITS = 12
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output      logic             s_ready,
    input  wire in_t              s_data,
    input  wire logic             hold,
    input  wire logic [CFG_W-1:0] cfg_ics,
    output      logic             push,
    output      cmd_t             push_data,
    input  wire logic             full
);

    localparam int LIMIT = ((1 << MAX_CODE_BITS) < TABLE_DEPTH) ?
                           (1 << MAX_CODE_BITS) : TABLE_DEPTH;
    localparam logic [12:0]      LIMIT13 = 13'(LIMIT);
    localparam logic [CFG_W-1:0] CW_MAX  = CFG_W'(MAX_CODE_BITS);

    fr_state_t         state_reg, state_next;
    logic [19:0]       bb_reg, bb_next;
    logic [4:0]        bc_reg, bc_next;
    logic [CFG_W-1:0]  cw_reg, cw_next;
    logic [12:0]       nfc_reg, nfc_next;
    logic              ac_reg, ac_next;
    logic              ended_reg, ended_next;
    logic              start_reg, start_next;

    logic [CFG_W-1:0]  ics;
    logic [12:0]       clear_code;
    logic [12:0]       eoi_code;
    logic [12:0]       cmask;
    logic [CODE_W-1:0] code;
    logic              have_code;
    logic              is_clear;
    logic              is_eoi;
    logic              need_push;
    logic              step;
    logic              accept;
    logic [12:0]       nfc_add;
    logic [19:0]       bb_base;
    logic [4:0]        bc_base;
    logic              ended_base;

    assign ics        = eff_ics(cfg_ics);
    assign clear_code = 13'd1 << ics;
    assign eoi_code   = clear_code + 13'd1;
    assign cmask      = (13'd1 << cw_reg) - 13'd1;
    assign code       = bb_reg[CODE_W-1:0] & cmask[CODE_W-1:0];
    assign have_code  = !ended_reg && (bc_reg >= {1'b0, cw_reg});
    assign is_eoi     = ({1'b0, code} == eoi_code);
    assign is_clear   = ({1'b0, code} == clear_code);
    // A clear code only resets local state and sends nothing downstream.
    assign need_push  = !(have_code && is_clear && !is_eoi);
    assign step       = (state_reg == FR_BUSY) && (!need_push || !full);
    assign s_ready    = (state_reg == FR_IDLE) && !hold;
    assign accept     = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE: begin
                if (accept) state_next = FR_BUSY;
            end
            FR_BUSY: begin
                if (step && !have_code) state_next = FR_IDLE;
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_comb begin
        bb_next    = bb_reg;
        bc_next    = bc_reg;
        cw_next    = cw_reg;
        nfc_next   = nfc_reg;
        ac_next    = ac_reg;
        ended_next = ended_reg;
        start_next = start_reg;
        push       = 1'b0;
        push_data  = '0;
        bb_base    = bb_reg;
        bc_base    = bc_reg;
        ended_base = ended_reg;
        nfc_add    = nfc_reg;
        case (state_reg)
            FR_IDLE: begin
                if (accept) begin
                    start_next = s_data.image_start;
                    if (s_data.image_start) begin
                        bb_base    = '0;
                        bc_base    = '0;
                        ended_base = 1'b0;
                        cw_next    = ics + 4'd1;
                        nfc_next   = clear_code + 13'd2;
                        ac_next    = 1'b0;
                    end
                    ended_next = ended_base;
                    bb_next    = bb_base;
                    bc_next    = bc_base;
                    if (!ended_base) begin
                        bb_next = bb_base | (20'(s_data.data_byte) << bc_base);
                        bc_next = bc_base + 5'd8;
                    end
                end
            end
            FR_BUSY: begin
                if (step) begin
                    push_data.start = start_reg;
                    push_data.code  = code;
                    if (have_code) begin
                        bb_next = bb_reg >> cw_reg;
                        bc_next = bc_reg - {1'b0, cw_reg};
                        if (is_eoi) begin
                            push           = 1'b1;
                            push_data.kind = CMD_EOI;
                            ended_next     = 1'b1;
                            bb_next        = '0;
                            bc_next        = '0;
                        end else if (is_clear) begin
                            cw_next  = ics + 4'd1;
                            nfc_next = clear_code + 13'd2;
                            ac_next  = 1'b1;
                        end else if (ac_reg) begin
                            ac_next        = 1'b0;
                            push           = 1'b1;
                            push_data.kind = CMD_LIT;
                        end else begin
                            push              = 1'b1;
                            push_data.kind    = CMD_DATA;
                            push_data.unknown = ({1'b0, code} >= nfc_reg);
                            push_data.add     = (nfc_reg < LIMIT13);
                            push_data.addr    = nfc_reg[CODE_W-1:0];
                            if (nfc_reg < LIMIT13) nfc_add = nfc_reg + 13'd1;
                            nfc_next = nfc_add;
                            if ((nfc_add >= (13'd1 << cw_reg)) && (cw_reg < CW_MAX)) begin
                                cw_next = cw_reg + 4'd1;
                            end
                        end
                    end else begin
                        push           = 1'b1;
                        push_data.kind = CMD_END;
                    end
                    if (push) start_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
            bb_reg    <= '0;
            bc_reg    <= '0;
            cw_reg    <= eff_ics(ICS_RESET) + 4'd1;
            nfc_reg   <= (13'd1 << eff_ics(ICS_RESET)) + 13'd2;
            ac_reg    <= 1'b0;
            ended_reg <= 1'b0;
            start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            bb_reg    <= bb_next;
            bc_reg    <= bc_next;
            cw_reg    <= cw_next;
            nfc_reg   <= nfc_next;
            ac_reg    <= ac_next;
            ended_reg <= ended_next;
            start_reg <= start_next;
        end
    end

endmodule

`default_nettype wire

[sv/gld_back.sv]
// Back end: walks the dictionary chain, reverses strings through a stack and
// packs pixels into result transactions. Depends on gld_pkg and gld_ram.
`default_nettype none

module gld_back
    import gld_pkg::*;
#(
    parameter int TABLE_DEPTH       = 4096,
    parameter int MAX_STRING        = 1024,
    parameter int PIXELS_PER_RESULT = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [CFG_W-1:0] cfg_cb,
    input  wire logic             fifo_empty,
    input  wire cmd_t             fifo_head,
    output      logic             fifo_pop,
    output      logic             clearing,
    output      logic             m_valid,
    input  wire logic             m_ready,
    output      out_t             m_data
);

    localparam int IDXW   = $clog2(TABLE_DEPTH);
    localparam int SDEPTH = MAX_STRING + 2;
    localparam int SW     = $clog2(SDEPTH);
    localparam int SPW    = $clog2(MAX_STRING + 3);
    localparam int GW     = $clog2(PIXELS_PER_RESULT);
    localparam int TW     = CODE_W + PIX_W;
    localparam logic [12:0]     TD13     = 13'(TABLE_DEPTH);
    localparam logic [6:0]      PPR7     = 7'(PIXELS_PER_RESULT);
    localparam logic [SPW-1:0]  SP_LIMIT = SPW'(MAX_STRING);
    localparam logic [IDXW-1:0] CLR_LAST = IDXW'(TABLE_DEPTH - 1);

    bk_state_t         state_reg, state_next;
    status_t           status_reg, status_next;
    logic              halted_reg, halted_next;
    logic [CODE_W-1:0] prev_reg, prev_next;
    logic [PIX_W-1:0]  first_reg, first_next;
    logic [CODE_W-1:0] cur_reg, cur_next;
    logic              oor_reg, oor_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic              pv_reg, pv_next;
    cmd_t              cmd_reg, cmd_next;
    logic [PIX_W-1:0]  grp_reg [PIXELS_PER_RESULT];
    logic [PIX_W-1:0]  grp_next [PIXELS_PER_RESULT];
    logic [6:0]        cnt_reg, cnt_next;
    logic [IDXW-1:0]   clr_reg, clr_next;
    logic              outv_reg, outv_next;
    out_t              out_reg, out_next;

    logic              t_we, t_re;
    logic [IDXW-1:0]   t_waddr, t_raddr;
    logic [TW-1:0]     t_wdata, t_rdata;
    logic              s_we, s_re;
    logic [SW-1:0]     s_waddr, s_raddr;
    logic [PIX_W-1:0]  s_wdata, s_rdata;

    logic [PIX_W-1:0]  mask8;
    logic              out_free;
    logic              can_put;
    status_t           status_now;
    logic [CODE_W-1:0] prev_now;
    logic [PIX_W-1:0]  first_now;
    logic              running;
    logic              need_flush;
    logic              idle_go;
    logic [CODE_W-1:0] cur_start;
    logic [PIX_W-1:0]  tsuf;
    logic [CODE_W-1:0] tpre;
    logic              w_deep;
    logic              w_err;
    logic              issue;
    logic              cons;
    logic              pop_done;
    logic [PIX_W-1:0]  fc;
    logic [SPW-1:0]    sp_dec;

    logic              put_en;
    logic [PIX_W-1:0]  put_px;
    logic              fin_en;
    logic              fin_eoi;
    logic              fin_err;
    logic              load;
    out_t              load_data;
    logic [511:0]      flat;

    gld_ram #(.WIDTH(TW), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .re    (t_re),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    gld_ram #(.WIDTH(PIX_W), .DEPTH(SDEPTH)) u_stack (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign mask8      = 8'((9'd1 << eff_cb(cfg_cb)) - 9'd1);
    assign out_free   = !outv_reg || m_ready;
    assign can_put    = (cnt_reg != PPR7) || out_free;
    assign status_now = fifo_head.start ? ST_RUNNING : status_reg;
    assign prev_now   = fifo_head.start ? '0 : prev_reg;
    assign first_now  = fifo_head.start ? '0 : first_reg;
    assign running    = (status_now == ST_RUNNING);
    assign need_flush = (cnt_reg != 7'd0) || halted_reg;
    assign cur_start  = fifo_head.unknown ? prev_now : fifo_head.code;

    always_comb begin
        case (fifo_head.kind)
            CMD_END: idle_go = !need_flush || out_free;
            CMD_LIT: idle_go = !running || can_put;
            default: idle_go = 1'b1;
        endcase
    end

    assign fifo_pop = (state_reg == BK_IDLE) && !fifo_empty && idle_go;
    assign clearing = (state_reg == BK_CLEAR);

    // Entries beyond the table read as zero prefix and zero suffix.
    assign tsuf     = oor_reg ? '0 : t_rdata[PIX_W-1:0];
    assign tpre     = oor_reg ? '0 : t_rdata[TW-1:PIX_W];
    assign w_deep   = (cur_reg > {4'd0, mask8});
    assign w_err    = w_deep && (sp_reg > SP_LIMIT);
    assign fc       = cur_reg[PIX_W-1:0] & mask8;
    assign issue    = (sp_reg != '0) && (!pv_reg || can_put);
    assign cons     = pv_reg && can_put;
    assign pop_done = (sp_reg == '0) && !pv_reg;
    assign sp_dec   = sp_reg - 1'b1;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR: begin
                if (clr_reg == CLR_LAST) state_next = BK_IDLE;
            end
            BK_IDLE: begin
                if (fifo_pop && (fifo_head.kind == CMD_DATA) && running) begin
                    state_next = BK_WALK;
                end
            end
            BK_WALK: begin
                if (w_err) begin
                    state_next = BK_IDLE;
                end else if (!w_deep) begin
                    state_next = BK_POP;
                end
            end
            BK_POP: begin
                if (pop_done) state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        flat = '0;
        for (int i = 0; i < PIXELS_PER_RESULT; i++) begin
            flat[8*i +: 8] = grp_reg[i];
        end
    end

    always_comb begin
        status_next = status_reg;
        halted_next = halted_reg;
        prev_next   = prev_reg;
        first_next  = first_reg;
        cur_next    = cur_reg;
        oor_next    = oor_reg;
        sp_next     = sp_reg;
        pv_next     = pv_reg;
        cmd_next    = cmd_reg;
        clr_next    = clr_reg;
        t_we        = 1'b0;
        t_waddr     = '0;
        t_wdata     = '0;
        t_re        = 1'b0;
        t_raddr     = '0;
        s_we        = 1'b0;
        s_waddr     = '0;
        s_wdata     = '0;
        s_re        = 1'b0;
        s_raddr     = '0;
        put_en      = 1'b0;
        put_px      = '0;
        fin_en      = 1'b0;
        fin_eoi     = 1'b0;
        fin_err     = 1'b0;
        case (state_reg)
            BK_CLEAR: begin
                t_we     = 1'b1;
                t_waddr  = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            BK_IDLE: begin
                if (fifo_pop) begin
                    if (fifo_head.start) begin
                        status_next = ST_RUNNING;
                        prev_next   = '0;
                        first_next  = '0;
                    end
                    case (fifo_head.kind)
                        CMD_END: begin
                            halted_next = 1'b0;
                            if (need_flush) begin
                                fin_en  = 1'b1;
                                fin_eoi = (status_now == ST_ENDED);
                                fin_err = (status_now == ST_ERROR);
                            end
                        end
                        CMD_EOI: begin
                            if (running) begin
                                status_next = ST_ENDED;
                                halted_next = 1'b1;
                            end
                        end
                        CMD_LIT: begin
                            if (running) begin
                                first_next = fifo_head.code[PIX_W-1:0] & mask8;
                                prev_next  = fifo_head.code;
                                put_en     = 1'b1;
                                put_px     = fifo_head.code[PIX_W-1:0] & mask8;
                            end
                        end
                        CMD_DATA: begin
                            if (running) begin
                                cmd_next = fifo_head;
                                cur_next = cur_start;
                                oor_next = ({1'b0, cur_start} >= TD13);
                                t_re     = 1'b1;
                                t_raddr  = cur_start[IDXW-1:0];
                                // A code not yet defined ends its string with first_now, pushed first.
                                if (fifo_head.unknown) begin
                                    s_we    = 1'b1;
                                    s_waddr = '0;
                                    s_wdata = first_now;
                                    sp_next = SPW'(1);
                                end else begin
                                    sp_next = '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_WALK: begin
                if (w_deep) begin
                    if (w_err) begin
                        status_next = ST_ERROR;
                        halted_next = 1'b1;
                    end else begin
                        s_we     = 1'b1;
                        s_waddr  = sp_reg[SW-1:0];
                        s_wdata  = tsuf;
                        sp_next  = sp_reg + 1'b1;
                        cur_next = tpre;
                        oor_next = ({1'b0, tpre} >= TD13);
                        t_re     = 1'b1;
                        t_raddr  = tpre[IDXW-1:0];
                    end
                end else begin
                    s_we       = 1'b1;
                    s_waddr    = sp_reg[SW-1:0];
                    s_wdata    = fc;
                    sp_next    = sp_reg + 1'b1;
                    first_next = fc;
                    pv_next    = 1'b0;
                    if (cmd_reg.add) begin
                        t_we    = 1'b1;
                        t_waddr = cmd_reg.addr[IDXW-1:0];
                        t_wdata = {prev_reg, fc};
                    end
                    prev_next = cmd_reg.code;
                end
            end
            BK_POP: begin
                // Read data holds while no new read is issued, so a stall keeps the pixel.
                if (cons) begin
                    put_en = 1'b1;
                    put_px = s_rdata;
                end
                if (issue) begin
                    s_re    = 1'b1;
                    s_raddr = sp_dec[SW-1:0];
                    sp_next = sp_dec;
                    pv_next = 1'b1;
                end else if (cons) begin
                    pv_next = 1'b0;
                end
            end
            default: ;
        endcase

        grp_next                = grp_reg;
        cnt_next                = cnt_reg;
        load                    = 1'b0;
        load_data               = '0;
        load_data.pixels_0      = flat[63:0];
        load_data.pixels_1      = flat[127:64];
        load_data.pixels_2      = flat[191:128];
        load_data.pixels_3      = flat[255:192];
        load_data.pixels_4      = flat[319:256];
        load_data.pixels_5      = flat[383:320];
        load_data.pixels_6      = flat[447:384];
        load_data.pixels_7      = flat[511:448];
        load_data.pixel_count   = cnt_reg;
        if (put_en) begin
            if (cnt_reg == PPR7) begin
                load = 1'b1;
                for (int i = 0; i < PIXELS_PER_RESULT; i++) begin
                    grp_next[i] = '0;
                end
                grp_next[0] = put_px;
                cnt_next    = 7'd1;
            end else begin
                grp_next[cnt_reg[GW-1:0]] = put_px;
                cnt_next = cnt_reg + 7'd1;
            end
        end
        if (fin_en) begin
            load                   = 1'b1;
            load_data.last         = 1'b1;
            load_data.end_of_image = fin_eoi;
            load_data.error        = fin_err;
            for (int i = 0; i < PIXELS_PER_RESULT; i++) begin
                grp_next[i] = '0;
            end
            cnt_next = 7'd0;
        end
        outv_next = load || (outv_reg && !m_ready);
        out_next  = load ? load_data : out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BK_CLEAR;
            status_reg <= ST_RUNNING;
            halted_reg <= 1'b0;
            prev_reg   <= '0;
            first_reg  <= '0;
            sp_reg     <= '0;
            pv_reg     <= 1'b0;
            cnt_reg    <= '0;
            clr_reg    <= '0;
            outv_reg   <= 1'b0;
            for (int i = 0; i < PIXELS_PER_RESULT; i++) begin
                grp_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            halted_reg <= halted_next;
            prev_reg   <= prev_next;
            first_reg  <= first_next;
            sp_reg     <= sp_next;
            pv_reg     <= pv_next;
            cnt_reg    <= cnt_next;
            clr_reg    <= clr_next;
            outv_reg   <= outv_next;
            grp_reg    <= grp_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        oor_reg <= oor_next;
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    assign m_valid = outv_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

[sv/gif_lzw_decoder.sv]
// GIF LZW raster decoder. Bytes of the unblocked raster stream enter on the
// s_ channel; pixel indices leave on the m_ channel in groups of up to
// PIXELS_PER_RESULT, the final group of each byte marked by last. A code
// is first unpacked, then its chain is walked through the dictionary and
// its pixels are unstacked, the chain walk through the dictionary RAM's
// single read port being the limiting loop. After reset the dictionary is
// swept to zero, one entry a cycle, and no byte is taken during the sweep;
// configuration writes are taken at any time.
`default_nettype none

module gif_lzw_decoder
    import gld_pkg::*;
#(
    parameter int TABLE_DEPTH       = 4096,
    parameter int MAX_CODE_BITS     = 12,
    parameter int MAX_STRING        = 1024,
    parameter int PIXELS_PER_RESULT = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output      logic               s_ready,
    input  wire in_t                s_data,
    output      logic               m_valid,
    input  wire logic               m_ready,
    output      out_t               m_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output      logic [31:0]        prdata,
    output      logic               pready
);

    localparam int QDEPTH = 4;

    logic [CFG_W-1:0] ics_reg;
    logic [CFG_W-1:0] cb_reg;
    logic             cfg_wr;

    logic             clearing;
    logic             push;
    cmd_t             push_data;
    logic             full;
    logic             pop;
    logic             empty;
    cmd_t             head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = {28'd0, (paddr[2] == REG_CB) ? cb_reg : ics_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ics_reg <= ICS_RESET;
            cb_reg  <= CB_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ICS) begin
                ics_reg <= pwdata[CFG_W-1:0];
            end else begin
                cb_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    gld_front #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .hold      (clearing),
        .cfg_ics   (ics_reg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    gld_fifo #(.DEPTH(QDEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    gld_back #(
        .TABLE_DEPTH       (TABLE_DEPTH),
        .MAX_STRING        (MAX_STRING),
        .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_cb     (cb_reg),
        .fifo_empty (empty),
        .fifo_head  (head),
        .fifo_pop   (pop),
        .clearing   (clearing),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

`ifndef ASSERT_OFF
    // A transaction that is not the last of its byte always carries a full group.
    a_full_group: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> (m_data.pixel_count == 7'(PIXELS_PER_RESULT)))
        else $error("partial group sent before the end of a byte");

    // End of image and error are only ever flagged on the final transaction.
    a_flag_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.end_of_image || m_data.error)) |-> m_data.last)
        else $error("status flag on a transaction that is not last");

    a_flag_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.end_of_image && m_data.error))
        else $error("end of image and error flagged together");

    // No byte may enter while the dictionary sweep is running.
    a_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready)
        else $error("byte taken during the dictionary sweep");
`endif

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for gif_lzw_decoder: raster bytes in, pixel groups out.
// Depends on gld_pkg and the decoder RTL; a built-in LZW decode predicts all but the hand-decoded groups.

module tb;
    import gld_pkg::*;

    localparam int DICT_SIZE   = 4096;
    localparam int STRING_CAP  = 1024;
    localparam int GROUP_SIZE  = 64;
    localparam int GROUPS_CAP  = 51;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        in_t        d;
        logic       typed;
        logic       has_res;
        logic [6:0] n;
        logic       eoi;
    } feed_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_t                s_data;
    logic               m_valid;
    logic               m_ready;
    out_t               m_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    gif_lzw_decoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Decoder shadow state.
    logic [3:0]  reg_ics, reg_cb;
    int          bitbuf, bitcnt, width, free_code, prev_code, first_px;
    status_t     dec_status;
    bit          after_clr;
    logic [11:0] prefix_mem [0:DICT_SIZE-1];
    logic [7:0]  suffix_mem [0:DICT_SIZE-1];
    logic [7:0]  rev_stack [0:STRING_CAP+1];
    logic [7:0]  grp [0:GROUP_SIZE-1];
    int          grp_len;
    out_t        byte_groups [$];
    out_t        pixel_groups_due [$];

    // Stream packer state, mirroring the code width of the decoder.
    int          pk_bits, pk_n, pk_w, pk_free, pk_ics;
    bit          pk_after, pk_start;

    feed_t       feed_q [$];
    feed_t       offer;
    feed_t       dir_rows [0:18];
    int          errors, bytes_taken, groups_checked, idle_cycles;
    bit          quiet, hold_req;
    int          stall_left;

    function automatic int ics_now();
        return (reg_ics < 2) ? 2 : (reg_ics > 8) ? 8 : int'(reg_ics);
    endfunction

    function automatic int cb_now();
        return (reg_cb < 1) ? 1 : (reg_cb > 8) ? 8 : int'(reg_cb);
    endfunction

    task automatic restart_decoder();
        bitbuf = 0;
        bitcnt = 0;
        width = ics_now() + 1;
        free_code = (1 << ics_now()) + 2;
        prev_code = 0;
        first_px = 0;
        dec_status = ST_RUNNING;
        after_clr = 0;
    endtask

    task automatic emit_group(bit eoi, bit err);
        out_t        r;
        logic [63:0] w [0:7];
        int          i;
        if (byte_groups.size() >= GROUPS_CAP) begin
            grp_len = 0;
            return;
        end
        for (i = 0; i < 8; i++) w[i] = '0;
        for (i = 0; i < grp_len; i++) w[i/8][8*(i%8) +: 8] = grp[i];
        r = '0;
        r.pixels_0 = w[0]; r.pixels_1 = w[1]; r.pixels_2 = w[2]; r.pixels_3 = w[3];
        r.pixels_4 = w[4]; r.pixels_5 = w[5]; r.pixels_6 = w[6]; r.pixels_7 = w[7];
        r.pixel_count = grp_len[6:0];
        r.end_of_image = eoi;
        r.error = err;
        byte_groups.push_back(r);
        grp_len = 0;
    endtask

    task automatic add_pixel(int p);
        if (grp_len >= GROUP_SIZE) emit_group(0, 0);
        grp[grp_len] = p[7:0];
        grp_len++;
    endtask

    // Walks the chain of one data code, stacking suffixes, then unstacks them and adds the new table entry.
    task automatic expand_code(int code, int mask);
        int cur, sp, i;
        cur = code;
        sp = 0;
        if (cur >= free_code) begin
            cur = prev_code;
            rev_stack[sp] = first_px[7:0];
            sp++;
        end
        while (cur > mask) begin
            if (sp > STRING_CAP) begin
                dec_status = ST_ERROR;
                return;
            end
            rev_stack[sp] = suffix_mem[cur];
            cur = int'(prefix_mem[cur]);
            sp++;
        end
        first_px = cur & mask;
        rev_stack[sp] = first_px[7:0];
        sp++;
        for (i = sp; i > 0; i--) add_pixel(int'(rev_stack[i-1]));
        if (free_code < DICT_SIZE) begin
            prefix_mem[free_code] = prev_code[11:0];
            suffix_mem[free_code] = first_px[7:0];
            free_code++;
        end
        prev_code = code & 'hFFF;
        if (free_code >= (1 << width) && width < 12) width++;
    endtask

    task automatic decode_byte(in_t x);
        int ics, clr, eoi, mask, code;
        byte_groups.delete();
        grp_len = 0;
        if (x.image_start) restart_decoder();
        if (dec_status != ST_RUNNING) return;
        ics = ics_now();
        clr = 1 << ics;
        eoi = clr + 1;
        mask = (1 << cb_now()) - 1;
        bitbuf = bitbuf | (int'(x.data_byte) << bitcnt);
        bitcnt += 8;
        while (dec_status == ST_RUNNING && bitcnt >= width) begin
            code = bitbuf & ((1 << width) - 1);
            bitbuf = bitbuf >> width;
            bitcnt -= width;
            if (code == eoi) begin
                dec_status = ST_ENDED;
            end else if (code == clr) begin
                width = ics + 1;
                free_code = clr + 2;
                after_clr = 1;
            end else if (after_clr) begin
                after_clr = 0;
                prev_code = code;
                first_px = code & mask;
                add_pixel(first_px);
            end else begin
                expand_code(code, mask);
            end
        end
        if (dec_status == ST_ENDED) begin
            bitbuf = 0;
            bitcnt = 0;
        end
        if (grp_len > 0 || dec_status != ST_RUNNING)
            emit_group(dec_status == ST_ENDED, dec_status == ST_ERROR);
        if (byte_groups.size() > 0) byte_groups[byte_groups.size()-1].last = 1;
    endtask

    function automatic void cmp_field(string f, logic [63:0] e, logic [63:0] a);
        if (a !== e) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, f, e, a);
        end
    endfunction

    function automatic feed_t row(logic [7:0] b, bit st, bit typed, bit has, int n, bit eoi);
        feed_t f;
        f = '0;
        f.d.data_byte = b;
        f.d.image_start = st;
        f.typed = typed;
        f.has_res = has;
        f.n = n[6:0];
        f.eoi = eoi;
        return f;
    endfunction

    task automatic pk_begin(bit with_start);
        pk_ics = ics_now();
        pk_bits = 0;
        pk_n = 0;
        pk_w = pk_ics + 1;
        pk_free = (1 << pk_ics) + 2;
        pk_after = 0;
        pk_start = with_start;
    endtask

    task automatic pk_byte(int b);
        feed_q.push_back(row(b[7:0], pk_start, 0, 0, 0, 0));
        pk_start = 0;
    endtask

    task automatic pk_code(int c);
        int clr;
        clr = 1 << pk_ics;
        pk_bits = pk_bits | (c << pk_n);
        pk_n += pk_w;
        while (pk_n >= 8) begin
            pk_byte(pk_bits & 255);
            pk_bits = pk_bits >> 8;
            pk_n -= 8;
        end
        if (c == clr) begin
            pk_w = pk_ics + 1;
            pk_free = clr + 2;
            pk_after = 1;
        end else if (c == clr + 1) begin
        end else if (pk_after) begin
            pk_after = 0;
        end else begin
            if (pk_free < DICT_SIZE) pk_free++;
            if (pk_free >= (1 << pk_w) && pk_w < 12) pk_w++;
        end
    endtask

    task automatic pk_end();
        if (pk_n > 0) pk_byte((pk_bits | ($urandom << pk_n)) & 255);
        pk_n = 0;
        pk_bits = 0;
    endtask

    // One image: mostly well-formed codes, with clears, undefined codes and
    // the odd image that carries on from the previous decoder state.
    task automatic gen_image(int ncodes);
        int k, c, r, hi;
        pk_begin($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 4) != 0) pk_code(1 << pk_ics);
        for (k = 0; k < ncodes; k++) begin
            r = $urandom_range(0, 19);
            hi = pk_free;
            if (hi > (1 << pk_w) - 1) hi = (1 << pk_w) - 1;
            if (r == 0) c = 1 << pk_ics;
            else if (r == 1) c = hi;
            else if (r < 8) c = $urandom_range(0, (1 << pk_ics) - 1);
            else c = $urandom_range(0, hi);
            if (c == (1 << pk_ics) + 1) c = 0;
            pk_code(c);
        end
        if ($urandom_range(0, 1)) pk_code((1 << pk_ics) + 1);
        pk_end();
    endtask

    task automatic reg_write(logic idx, logic [3:0] v);
        logic [31:0] wd;
        wd = $urandom;
        wd[3:0] = v;
        @(negedge aclk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= wd;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (idx == REG_ICS) reg_ics = v;
        else reg_cb = v;
    endtask

    task automatic play_feed();
        int gap, calm;
        calm = 0;
        while (feed_q.size() > 0) begin
            gap = 0;
            if (!quiet) begin
                if (calm > 0) begin
                    calm--;
                end else if ($urandom_range(0, 19) == 0) begin
                    calm = $urandom_range(10, 30);
                end else begin
                    gap = $urandom_range(0, 9);
                    gap = (gap < 5) ? 0 : (gap < 9) ? $urandom_range(1, 3)
                                                    : $urandom_range(20, 60);
                end
            end
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            offer = feed_q.pop_front();
            s_valid <= 1;
            s_data <= offer.d;
            do @(posedge aclk); while (!s_ready);
        end
        @(negedge aclk);
        s_valid <= 0;
    endtask

    task automatic drain();
        while (pixel_groups_due.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // Receiver side: random stalls, and one long hold-off on request.
    initial begin
        m_ready = 0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 0;
            end else if (!quiet && $urandom_range(0, 9) < 3) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 2);
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    // Results are checked before the byte accepted at the same edge is decoded.
    always @(posedge aclk) begin
        out_t e, t;
        int   i;
        if (aresetn) begin
            idle_cycles++;
            if (m_valid && m_ready) begin
                idle_cycles = 0;
                groups_checked++;
                if (pixel_groups_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction on the result channel: %h",
                             $time, m_data);
                end else begin
                    e = pixel_groups_due.pop_front();
                    cmp_field("pixels_0", e.pixels_0, m_data.pixels_0);
                    cmp_field("pixels_1", e.pixels_1, m_data.pixels_1);
                    cmp_field("pixels_2", e.pixels_2, m_data.pixels_2);
                    cmp_field("pixels_3", e.pixels_3, m_data.pixels_3);
                    cmp_field("pixels_4", e.pixels_4, m_data.pixels_4);
                    cmp_field("pixels_5", e.pixels_5, m_data.pixels_5);
                    cmp_field("pixels_6", e.pixels_6, m_data.pixels_6);
                    cmp_field("pixels_7", e.pixels_7, m_data.pixels_7);
                    cmp_field("pixel_count", 64'(e.pixel_count), 64'(m_data.pixel_count));
                    cmp_field("last", 64'(e.last), 64'(m_data.last));
                    cmp_field("end_of_image", 64'(e.end_of_image),
                              64'(m_data.end_of_image));
                    cmp_field("error", 64'(e.error), 64'(m_data.error));
                end
            end
            if (s_valid && s_ready) begin
                idle_cycles = 0;
                bytes_taken++;
                decode_byte(offer.d);
                if (offer.typed) begin
                    if (offer.has_res) begin
                        t = '0;
                        t.pixel_count = offer.n;
                        t.last = 1;
                        t.end_of_image = offer.eoi;
                        pixel_groups_due.push_back(t);
                    end
                end else begin
                    for (i = 0; i < byte_groups.size(); i++)
                        pixel_groups_due.push_back(byte_groups[i]);
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int ph, k;
        logic [3:0] cfg_ics [0:4];
        logic [3:0] cfg_cb [0:4];
        cfg_ics = '{4'd0, 4'd15, 4'd2, 4'd8, 4'd5};
        cfg_cb  = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd3};
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        offer = '0;
        errors = 0;
        bytes_taken = 0;
        groups_checked = 0;
        idle_cycles = 0;
        quiet = 0;
        hold_req = 0;
        reg_ics = ICS_RESET;
        reg_cb = CB_RESET;
        for (k = 0; k < DICT_SIZE; k++) begin
            prefix_mem[k] = '0;
            suffix_mem[k] = '0;
        end
        restart_decoder();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        reg_write(REG_ICS, 4'd8);
        reg_write(REG_CB, 4'd8);
        // Hand-decoded opening at 9-bit codes: a lone literal, an end code,
        // a halted byte, then clear followed by end; the rest are extremes.
        dir_rows = '{
            row(8'h00, 1, 1, 0, 0, 0), row(8'h00, 0, 1, 1, 1, 0),
            row(8'h01, 1, 1, 0, 0, 0), row(8'h01, 0, 1, 1, 0, 1),
            row(8'hA5, 0, 1, 0, 0, 0), row(8'h00, 1, 1, 0, 0, 0),
            row(8'h03, 0, 1, 0, 0, 0), row(8'h02, 0, 1, 1, 0, 1),
            row(8'hFF, 1, 0, 0, 0, 0), row(8'hFF, 0, 0, 0, 0, 0),
            row(8'hFF, 0, 0, 0, 0, 0), row(8'h80, 0, 0, 0, 0, 0),
            row(8'h7F, 0, 0, 0, 0, 0), row(8'h00, 0, 0, 0, 0, 0),
            row(8'hFF, 0, 0, 0, 0, 0), row(8'h55, 0, 0, 0, 0, 0),
            row(8'hAA, 0, 0, 0, 0, 0), row(8'h0F, 0, 0, 0, 0, 0),
            row(8'hF0, 0, 0, 0, 0, 0)
        };
        for (k = 0; k < 19; k++) feed_q.push_back(dir_rows[k]);
        play_feed();
        drain();

        for (ph = 0; ph < 5; ph++) begin
            reg_write(REG_ICS, cfg_ics[ph]);
            reg_write(REG_CB, cfg_cb[ph]);
            while (feed_q.size() < 10) begin
                if ($urandom_range(0, 5) == 0)
                    feed_q.push_back(row(8'($urandom), $urandom_range(0, 1), 0, 0, 0, 0));
                else
                    gen_image($urandom_range(3, 25));
            end
            if (ph == 1) hold_req = 1;
            play_feed();
            drain();
        end

        reg_write(REG_ICS, 4'd4);
        reg_write(REG_CB, 4'd6);
        while (feed_q.size() < 10) gen_image($urandom_range(3, 25));
        play_feed();
        drain();

        $display("Decoded %0d bytes into %0d pixel groups over seven register settings,",
                 bytes_taken, groups_checked);
        $display("including out-of-range settings, undefined codes and a long receiver stall.");
        if (errors == 0 && pixel_groups_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/gld_pkg.sv
sv/gld_ram.sv
sv/gld_fifo.sv
sv/gld_front.sv
sv/gld_back.sv
sv/gif_lzw_decoder.sv
dv/tb.sv
